// ----- rtl/pixel_keystream_cipher_unit_defines.svh -----
// Assertion macros for the pixel keystream cipher unit.
// Included by the top level; no other dependencies.
`ifndef PIXEL_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH
`define PIXEL_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication check
`define PKC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check
`define PKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pkc_pkg.sv -----
// Shared types and constants for the pixel keystream cipher unit.
// No dependencies.
`timescale 1ns / 1ps

package pkc_pkg;

   // Command kinds produced by the front end
   typedef enum logic {
      PKC_OP_STEP,
      PKC_OP_SEED
   } pkc_op_type;

   // Command word that travels through the queue beside the pixel
   typedef struct packed {
      pkc_op_type op;
      logic       decode;
   } pkc_cmd_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      PKC_IDLE,
      PKC_MULT,
      PKC_DIV,
      PKC_DONE
   } pkc_state_type;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_BITS   = 1;

   // Register map
   localparam int unsigned CSR_ADDR_BITS    = 4;
   localparam logic [1:0]  CSR_PIXEL_MAX    = 2'd0;
   localparam logic [1:0]  CSR_CIPHER_KEY   = 2'd1;
   localparam logic [1:0]  CSR_DECRYPT_MODE = 2'd2;

   // Generator width
   localparam int unsigned GEN_BITS = 31;

endpackage

// ----- rtl/pkc_front.sv -----
// Front end: accepts pixels, tags them as seed or step commands and
// buffers them in a two-entry queue. Depends on pkc_pkg.
`timescale 1ns / 1ps

module pkc_front import pkc_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [PIXEL_BITS-1:0] in_pixel,
   input  logic                  in_start,
   input  logic                  decrypt_mode,
   output logic                  q_valid,
   input  logic                  q_pop,
   output pkc_cmd_type           q_cmd,
   output logic [PIXEL_BITS-1:0] q_pixel
);

   pkc_cmd_type           cmd_ff   [QUEUE_DEPTH];
   logic [PIXEL_BITS-1:0] pix_ff   [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]    count_ff, count_in;
   logic                  push;
   pkc_cmd_type           new_cmd;

   // Classify the incoming item
   always_comb begin
      new_cmd.op     = in_start ? PKC_OP_SEED : PKC_OP_STEP;
      new_cmd.decode = decrypt_mode;
   end

   assign in_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != '0);
   assign q_cmd    = cmd_ff[rd_ptr_ff];
   assign q_pixel  = pix_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= new_cmd;
         pix_ff[wr_ptr_ff] <= in_pixel;
      end
   end

endmodule

// ----- rtl/pkc_back.sv -----
// Back end: Lehmer generator step, bit-serial modulo reduction of the
// keystream and the pixel, final add or subtract and the result register.
// Depends on pkc_pkg.
`timescale 1ns / 1ps

module pkc_back import pkc_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PIXEL_BITS-1:0] pixel_max,
   input  logic [GEN_BITS-1:0]   cipher_key,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  pkc_cmd_type           q_cmd,
   input  logic [PIXEL_BITS-1:0] q_pixel,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [PIXEL_BITS-1:0] out_pixel
);

   localparam int unsigned MULT_BITS  = 15;
   localparam int unsigned PROD_BITS  = GEN_BITS + MULT_BITS;
   localparam logic [MULT_BITS-1:0] LEHMER_MULT = 15'd16807;
   localparam logic [GEN_BITS-1:0]  LEHMER_MOD  = 31'h7FFF_FFFF;
   localparam int unsigned DIV_STEPS  = GEN_BITS;
   localparam int unsigned CNT_BITS   = 5;

   pkc_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [PROD_BITS-1:0]  product_ff;
   logic [GEN_BITS-1:0]   gen_ff;
   logic [GEN_BITS-1:0]   sdiv_ff;
   logic [GEN_BITS-1:0]   pdiv_ff;
   logic [PIXEL_BITS-1:0] srem_ff;
   logic [PIXEL_BITS-1:0] prem_ff;
   pkc_cmd_type           cmd_ff;
   logic                  out_valid_ff;
   logic [PIXEL_BITS-1:0] out_pixel_ff;

   logic                  mult_load;
   logic                  fold_load;
   logic                  div_step;
   logic                  out_load;
   logic [GEN_BITS-1:0]   seed_src;
   logic [GEN_BITS:0]     fold_sum;
   logic [GEN_BITS-1:0]   fold_val;
   logic [PIXEL_BITS:0]   modulus;
   logic [PIXEL_BITS:0]   enc_sum;
   logic [PIXEL_BITS:0]   dec_sum;
   logic [PIXEL_BITS:0]   final_val;

   // One restoring step: shift in a dividend bit, subtract modulus if it fits
   function automatic logic [PIXEL_BITS-1:0] mod_step(
      input logic [PIXEL_BITS-1:0] r,
      input logic                  b,
      input logic [PIXEL_BITS:0]   m
   );
      logic [PIXEL_BITS:0] t;
      t = {r, b};
      if (t >= m) begin
         t = t - m;
      end
      return t[PIXEL_BITS-1:0];
   endfunction

   assign modulus = {1'b0, pixel_max} + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PKC_IDLE: begin
            if (q_valid) state_in = PKC_MULT;
         end
         PKC_MULT: state_in = PKC_DIV;
         PKC_DIV: begin
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) state_in = PKC_DONE;
         end
         PKC_DONE: begin
            if (!out_valid_ff || out_ready) state_in = PKC_IDLE;
         end
         default: state_in = PKC_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      mult_load = 1'b0;
      fold_load = 1'b0;
      div_step  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         PKC_IDLE: mult_load = q_valid;
         PKC_MULT: fold_load = 1'b1;
         PKC_DIV:  div_step  = 1'b1;
         PKC_DONE: out_load  = !out_valid_ff || out_ready;
         default: ;
      endcase
   end

   assign q_pop = mult_load;

   // Generator: fold the product modulo 2^31-1 (high part added to low part)
   assign seed_src = (q_cmd.op == PKC_OP_SEED) ? cipher_key : gen_ff;
   always_comb begin
      fold_sum = {{(GEN_BITS+1-MULT_BITS){1'b0}}, product_ff[PROD_BITS-1:GEN_BITS]}
               + {1'b0, product_ff[GEN_BITS-1:0]};
      if (fold_sum >= {1'b0, LEHMER_MOD}) begin
         fold_sum = fold_sum - {1'b0, LEHMER_MOD};
      end
      fold_val = fold_sum[GEN_BITS-1:0];
   end

   // Combine reduced pixel and keystream
   always_comb begin
      enc_sum = {1'b0, prem_ff} + {1'b0, srem_ff};
      if (enc_sum >= modulus) begin
         enc_sum = enc_sum - modulus;
      end
      if (prem_ff >= srem_ff) begin
         dec_sum = {1'b0, prem_ff} - {1'b0, srem_ff};
      end else begin
         dec_sum = {1'b0, prem_ff} + modulus - {1'b0, srem_ff};
      end
      final_val = cmd_ff.decode ? dec_sum : enc_sum;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PKC_IDLE;
         gen_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fold_load) begin
            gen_ff <= fold_val;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (mult_load) begin
         product_ff <= seed_src * LEHMER_MULT;
         cmd_ff     <= q_cmd;
         pdiv_ff    <= GEN_BITS'(q_pixel);
      end
      if (fold_load) begin
         sdiv_ff <= fold_val;
         srem_ff <= '0;
         prem_ff <= '0;
         cnt_ff  <= '0;
      end
      if (div_step) begin
         srem_ff <= mod_step(srem_ff, sdiv_ff[GEN_BITS-1], modulus);
         prem_ff <= mod_step(prem_ff, pdiv_ff[GEN_BITS-1], modulus);
         sdiv_ff <= {sdiv_ff[GEN_BITS-2:0], 1'b0};
         pdiv_ff <= {pdiv_ff[GEN_BITS-2:0], 1'b0};
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (out_load) begin
         out_pixel_ff <= final_val[PIXEL_BITS-1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;

endmodule

// ----- rtl/pixel_keystream_cipher_unit.sv -----
// Top level of the pixel keystream cipher unit: register file, front end,
// back end. Depends on pkc_pkg, pkc_front, pkc_back and the defines header.
`timescale 1ns / 1ps
`include "pixel_keystream_cipher_unit_defines.svh"

// Usage:
// Pixels enter on the req_ stream (tdata = pixel_in, tuser = start_of_image)
// and leave on the rsp_ stream (tdata = pixel_out), one result per pixel.
// A pixel with start_of_image set reloads the generator from cipher_key
// before its keystream value is drawn. The csr_ port holds pixel_max (0x0),
// cipher_key (0x4) and decrypt_mode (0x8); write them while no pixel is in
// flight.
// Each pixel passes through the back end in order: the multiply into the
// product register, the fold into the generator, the bit-serial modulo unit
// and the result register. The back end takes a new pixel from the queue only
// once the last result is loaded; the modulo unit sets the time per pixel.
// A two-entry queue lets up to two further pixels be taken while one is
// worked on; when rsp_tready is low the finished result waits in the output
// register and the back end holds, then req_tready drops once the queue fills.
// Reset empties the queue and result register, clears the generator state
// and restores pixel_max 255, cipher_key 1, decrypt_mode 0.

module pixel_keystream_cipher_unit import pkc_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] pixel_in
   input  logic                     req_tuser,   // [0] start_of_image
   // Result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // [15:0] pixel_out
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [15:0]           pixel_max_ff, pixel_max_in;
   logic [GEN_BITS-1:0]   cipher_key_ff, cipher_key_in;
   logic                  decrypt_ff, decrypt_in;
   logic                  csr_write;
   logic [1:0]            csr_index;

   logic                  q_valid;
   logic                  q_pop;
   pkc_cmd_type           q_cmd;
   logic [PIXEL_BITS-1:0] q_pixel;
   logic [PIXEL_BITS-1:0] out_pixel;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      pixel_max_in  = pixel_max_ff;
      cipher_key_in = cipher_key_ff;
      decrypt_in    = decrypt_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PIXEL_MAX:    pixel_max_in  = csr_pwdata[15:0];
            CSR_CIPHER_KEY:   cipher_key_in = csr_pwdata[GEN_BITS-1:0];
            CSR_DECRYPT_MODE: decrypt_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_max_ff  <= 16'd255;
         cipher_key_ff <= 31'd1;
         decrypt_ff    <= 1'b0;
      end else begin
         pixel_max_ff  <= pixel_max_in;
         cipher_key_ff <= cipher_key_in;
         decrypt_ff    <= decrypt_in;
      end
   end

   // Read-back mux
   always_comb begin
      case (csr_index)
         CSR_PIXEL_MAX:    csr_prdata = 32'(pixel_max_ff);
         CSR_CIPHER_KEY:   csr_prdata = 32'(cipher_key_ff);
         CSR_DECRYPT_MODE: csr_prdata = 32'(decrypt_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Front end: intake and queue
   pkc_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_pixel     (req_tdata[PIXEL_BITS-1:0]),
      .in_start     (req_tuser),
      .decrypt_mode (decrypt_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_cmd        (q_cmd),
      .q_pixel      (q_pixel)
   );

   // Back end: generator, modulo unit, result register
   pkc_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pixel_max  (pixel_max_ff[PIXEL_BITS-1:0]),
      .cipher_key (cipher_key_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .q_pixel    (q_pixel),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixel  (out_pixel)
   );

   assign rsp_tdata = 16'(out_pixel);

   // Checks
   `PKC_ASSERT_NEXT(a_push_fills_queue, clock, reset, req_tvalid && req_tready, q_valid,
      "queue empty after an input transfer")
   `PKC_ASSERT_SAME(a_pop_needs_entry, clock, reset, q_pop, q_valid,
      "back end popped an empty queue")
   `PKC_ASSERT_SAME(a_stall_means_full, clock, reset, !req_tready, q_valid,
      "input stalled with an empty queue")

endmodule

// ----- bench/pixel_keystream_checker.sv -----
// Scoreboard for the pixel keystream cipher unit: follows register writes,
// predicts every output pixel and compares it with the rsp_ stream.
// Depends on pkc_pkg for the register map.
`timescale 1ns / 1ps

module pixel_keystream_checker import pkc_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] pixel_in
   input  logic                     req_tuser,   // [0] start_of_image
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [15:0]              rsp_tdata,   // [15:0] pixel_out
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output int                       mismatch_count,
   output int                       results_pending
);

   localparam longint unsigned LEHMER_MULT = 64'd16807;
   localparam longint unsigned LEHMER_MOD  = 64'd2147483647;
   localparam logic [15:0]     PIX_MASK    = 16'((32'd1 << PIXEL_BITS) - 1);

   localparam logic [15:0]     PIXEL_MAX_INIT = 16'd255;
   localparam logic [30:0]     KEY_INIT       = 31'd1;

   // Register copies and generator
   logic [15:0] pixel_max_q;
   logic [30:0] key_q;
   logic        decode_q;
   logic [30:0] lehmer_state;

   // Pixels still owed by the block, oldest first
   logic [15:0] expected_pixels[$];

   // One step of the multiplicative generator
   function automatic logic [30:0] lehmer_next(input logic [30:0] s);
      longint unsigned prod;
      prod = 64'(s) * LEHMER_MULT;
      return 31'(prod % LEHMER_MOD);
   endfunction

   // Add or remove the keystream value modulo pixel_max+1
   function automatic logic [15:0] mix_pixel(input logic [15:0] pix,
                                             input logic [30:0] s,
                                             input logic [15:0] pmax,
                                             input logic        decode);
      logic [16:0] modulus;
      logic [16:0] key_val;
      logic [17:0] sum;
      modulus = {1'b0, pmax & PIX_MASK} + 17'd1;
      key_val = 17'(s % modulus);
      if (decode)
         sum = {2'b00, pix & PIX_MASK} + modulus - key_val;
      else
         sum = {2'b00, pix & PIX_MASK} + key_val;
      return 16'(sum % modulus);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pixel_max_q    = PIXEL_MAX_INIT;
         key_q          = KEY_INIT;
         decode_q       = 1'b0;
         lehmer_state   = '0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_PIXEL_MAX:    pixel_max_q = csr_pwdata[15:0];
               CSR_CIPHER_KEY:   key_q       = csr_pwdata[30:0];
               CSR_DECRYPT_MODE: decode_q    = csr_pwdata[0];
               default: ;
            endcase
         end

         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out: no result expected, actual %0d", rsp_tdata);
               mismatch_count++;
            end else if (rsp_tdata !== expected_pixels[0]) begin
               $error("pixel_out: expected %0d, actual %0d",
                      expected_pixels[0], rsp_tdata);
               mismatch_count++;
               void'(expected_pixels.pop_front());
            end else begin
               void'(expected_pixels.pop_front());
            end
         end

         // pixel transfer: reseed if marked, advance, then mix
         if (req_tvalid && req_tready) begin
            if (req_tuser)
               lehmer_state = key_q;
            lehmer_state = lehmer_next(lehmer_state);
            expected_pixels.push_back(mix_pixel(req_tdata, lehmer_state,
                                                pixel_max_q, decode_q));
         end
      end
      results_pending = expected_pixels.size();
   end

endmodule

// ----- bench/tb_pixel_keystream_cipher_unit.sv -----
// Testbench top for the pixel keystream cipher unit: clock, reset, pixel
// stimulus, register settings and the verdict. Depends on pkc_pkg, the
// unit itself and pixel_keystream_checker.
`timescale 1ns / 1ps

module tb_pixel_keystream_cipher_unit import pkc_pkg::*;;

   localparam int PIXEL_BITS     = 16;
   localparam int RESULT_LATENCY = 36;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 111;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [15:0]              req_tdata;   // [15:0] pixel_in
   logic                     req_tuser;   // [0] start_of_image
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [15:0]              rsp_tdata;   // [15:0] pixel_out
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   int mismatch_count;
   int results_pending;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_requests;
   int stall_cycles;

   always #4 clock = ~clock;

   pixel_keystream_cipher_unit #(.PIXEL_BITS(PIXEL_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pixel_keystream_checker #(.PIXEL_BITS(PIXEL_BITS)) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // Watchdog: cycles without any transfer or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: random back-pressure, plus a long hold-off on request
   initial begin
      int held;
      int holds_served;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(negedge clock);
            holds_served++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // One register write: setup cycle, then access until pready
   task automatic csr_transfer(input logic [1:0] reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   // Writes all three registers back to back, then releases the bus
   task automatic write_settings(input logic [15:0] pmax, input logic [30:0] key,
                                 input logic decode);
      csr_transfer(CSR_PIXEL_MAX, {16'd0, pmax});
      csr_transfer(CSR_CIPHER_KEY, {1'b0, key});
      csr_transfer(CSR_DECRYPT_MODE, {31'd0, decode});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Offers one pixel after a random gap; returns at the negedge after transfer
   task automatic send_pixel(input logic [15:0] pix, input logic sof);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= sof;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly in-range pixels, some anywhere in the 16-bit field
   task automatic send_image(input int count, input logic [15:0] pmax, input bit reseed);
      int i;
      logic [15:0] pix;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85)
            pix = 16'($urandom_range(int'(pmax)));
         else
            pix = 16'($urandom_range(65535));
         send_pixel(pix, reseed && (i == 0));
      end
   endtask

   // Stop offering and wait until every expected pixel has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
   endtask

   initial begin
      int phase;
      int sent;
      int burst;
      bit paused;
      logic [15:0] pmax;
      logic [30:0] key;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      tx_idle_pct   = 18;
      rx_idle_pct   = 45;
      hold_requests = 0;
      paused        = 1'b0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset settings; no start mark yet, so the keystream is zero
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd255, 1'b0);
      // reseed from the reset key, then in-range and out-of-range pixels
      send_pixel(16'd0, 1'b1);
      send_pixel(16'd255, 1'b0);
      send_pixel(16'd300, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      drain_results();

      // Full 16-bit modulus, largest legal key, decode
      write_settings(16'hFFFF, 31'h7FFFFFFE, 1'b1);
      send_pixel(16'd0, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hAAAA, 1'b0);
      send_pixel(16'h5555, 1'b0);
      drain_results();

      // Modulus of one: every output is zero
      write_settings(16'd0, 31'd12345, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'd7, 1'b0);
      drain_results();

      // Key equal to the generator modulus collapses to zero
      write_settings(16'd255, 31'h7FFFFFFF, 1'b0);
      send_pixel(16'd10, 1'b1);
      send_pixel(16'd20, 1'b0);
      drain_results();

      // Zero key, encode then decode
      write_settings(16'd255, 31'd0, 1'b0);
      send_pixel(16'd5, 1'b1);
      send_pixel(16'd6, 1'b0);
      drain_results();
      write_settings(16'd255, 31'd0, 1'b1);
      send_pixel(16'd3, 1'b0);
      drain_results();

      // Wrap past the top of a 16-bit pixel
      write_settings(16'hFFFF, 31'd12345, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'd1, 1'b0);
      drain_results();

      // Random images under a series of settings
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 4) begin
            tx_idle_pct = 18;
            rx_idle_pct = 45;
         end else if (phase < 8) begin
            tx_idle_pct = 45;
            rx_idle_pct = 18;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         case (phase % 6)
            0: pmax = 16'hFFFF;
            1: pmax = 16'd255;
            2: pmax = 16'($urandom_range(65535));
            3: pmax = 16'd1;
            4: pmax = 16'($urandom_range(1023));
            default: pmax = 16'hFFFE;
         endcase
         case (phase % 4)
            1: key = 31'h7FFFFFFE;
            2: key = 31'd1;
            default: key = 31'($urandom_range(32'h7FFFFFFE));
         endcase
         write_settings(pmax, key, 1'($urandom_range(1)));

         // receiver stalls long enough for the input queue to fill
         if (phase == 5 || phase == 9)
            hold_requests++;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(48, 1);
            if (burst > PHASE_ITEMS - sent)
               burst = PHASE_ITEMS - sent;
            // an image now and then starts without a reseed
            send_image(burst, pmax, $urandom_range(9) != 0);
            sent += burst;
            if (phase == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
         drain_results();
      end

      // Let any stray result show up
      repeat (2 * RESULT_LATENCY) @(negedge clock);

      if (mismatch_count == 0 && results_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
